>>> hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console character writer package
// Shared widths, character codes, default geometry and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Field widths of the ports.
  localparam int CharW = 8;
  localparam int RowW  = 6;
  localparam int ColW  = 7;

  // Cells per ring row in the character buffer.
  localparam int Stride = 128;

  // Default console geometry.
  localparam int ColsDefault     = 80;
  localparam int VisibleDefault  = 30;
  localparam int RingRowsDefault = 64;

  // Control characters.
  localparam logic [CharW-1:0] CharBackspace = 8'd8;
  localparam logic [CharW-1:0] CharNewline   = 8'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ch_load;        // capture the input word
    logic mem_wr_char;    // store the character at the cursor
    logic col_inc;        // advance the cursor column
    logic col_dec_erase;  // clear the cell before the cursor and step back
    logic row_back;       // move the cursor to the previous ring row
    logic nl_start;       // next row, column zero, maybe scroll
    logic clr_step;       // clear one cell of the new row
    logic scan_start;     // read the last text cell of the cursor row
    logic scan_step;      // read the next cell toward column zero
    logic scan_hit;       // cursor goes one past the cell just read
    logic scan_empty;     // cursor goes to column zero
    logic wipe_step;      // clear one buffer cell after reset
    logic out_load;       // capture the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_bs;      // held word is a backspace
    logic is_nl;      // held word is a newline
    logic col_zero;   // cursor is at column zero
    logic on_top;     // cursor row is the top visible line
    logic wrap;       // a stored character reaches the row end
    logic clr_last;   // last cell of the row clear
    logic scan_nz;    // cell just read holds text
    logic scan_zero;  // cell just read is column zero
    logic wipe_last;  // last cell of the reset sweep
  } status_t;

endpackage

>>> hw/rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console character writer controller
// Sequences the reset sweep, decodes each character and steps the datapath
// through row clears and backward scans. Owns both handshakes.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  tcw_pkg::status_t st_i,
  output tcw_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] SWipe       = 3'd0;
  localparam logic [2:0] SIdle       = 3'd1;
  localparam logic [2:0] SDispatch   = 3'd2;
  localparam logic [2:0] SNlClr      = 3'd3;
  localparam logic [2:0] SScanStart  = 3'd4;
  localparam logic [2:0] SScan       = 3'd5;
  localparam logic [2:0] SFinish     = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Next state, commands and output valid.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      SWipe: begin
        cmd_o.wipe_step = 1'b1;
        if (st_i.wipe_last) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ch_load = 1'b1;
          state_d       = SDispatch;
        end
      end
      SDispatch: begin
        if (st_i.is_bs) begin
          if (!st_i.col_zero) begin
            cmd_o.col_dec_erase = 1'b1;
            state_d             = SFinish;
          end else if (st_i.on_top) begin
            state_d = SFinish;
          end else begin
            cmd_o.row_back = 1'b1;
            state_d        = SScanStart;
          end
        end else if (st_i.is_nl) begin
          cmd_o.nl_start = 1'b1;
          state_d        = SNlClr;
        end else begin
          cmd_o.mem_wr_char = 1'b1;
          if (st_i.wrap) begin
            cmd_o.nl_start = 1'b1;
            state_d        = SNlClr;
          end else begin
            cmd_o.col_inc = 1'b1;
            state_d       = SFinish;
          end
        end
      end
      SNlClr: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_last) begin
          state_d = SFinish;
        end
      end
      SScanStart: begin
        cmd_o.scan_start = 1'b1;
        state_d          = SScan;
      end
      SScan: begin
        if (st_i.scan_nz) begin
          cmd_o.scan_hit = 1'b1;
          state_d        = SFinish;
        end else if (st_i.scan_zero) begin
          cmd_o.scan_empty = 1'b1;
          state_d          = SFinish;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      SFinish: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SWipe;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// Text console character writer datapath
// Holds the character buffer, the cursor, the top line, the row clear and
// scan counters and the output register, and reports status to the controller.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLS      = tcw_pkg::ColsDefault,
  parameter int VISIBLE   = tcw_pkg::VisibleDefault,
  parameter int RING_ROWS = tcw_pkg::RingRowsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [tcw_pkg::CharW-1:0] char_code_i,
  input  tcw_pkg::cmd_t             cmd_i,
  output tcw_pkg::status_t          st_o,
  output logic [tcw_pkg::RowW-1:0]  cursor_row_o,
  output logic [tcw_pkg::ColW-1:0]  cursor_col_o,
  output logic [tcw_pkg::RowW-1:0]  top_line_o
);

  localparam int RowW  = tcw_pkg::RowW;
  localparam int ColW  = tcw_pkg::ColW;
  localparam int CharW = tcw_pkg::CharW;
  localparam int Depth = RING_ROWS * tcw_pkg::Stride;
  localparam int AddrW = $clog2(Depth);
  localparam int RowAw = AddrW - ColW;

  localparam logic [RowW-1:0] RowLast = RowW'(RING_ROWS - 1);
  localparam logic [ColW-1:0] ColLast = ColW'(COLS - 1);

  logic [CharW-1:0] ch_q;
  logic [RowW-1:0]  row_q, fv_q;
  logic [ColW-1:0]  col_q, clr_q, scan_q;
  logic [AddrW-1:0] wipe_q;
  logic [CharW-1:0] mem [Depth];
  logic [CharW-1:0] rdata_q;
  logic [RowW-1:0]  out_row_q, out_fv_q;
  logic [ColW-1:0]  out_col_q;

  logic [RowW-1:0]  row_next, row_prev, fv_next;
  logic [RowW:0]    used;
  logic             scroll;
  logic             wr_en, rd_en;
  logic [ColW-1:0]  wr_col, rd_col;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [CharW-1:0] wr_data;

  // Ring arithmetic for the row and the top line.
  always_comb begin
    row_next = (row_q == RowLast) ? '0 : row_q + 1'b1;
    row_prev = (row_q == '0) ? RowLast : row_q - 1'b1;
    fv_next  = (fv_q == RowLast) ? '0 : fv_q + 1'b1;
    used     = {1'b0, row_next} - {1'b0, fv_q}
             + ((row_next < fv_q) ? (RowW+1)'(RING_ROWS) : '0);
    scroll   = used >= (RowW+1)'(VISIBLE);
  end

  // Buffer port addressing; one write and one read port.
  always_comb begin
    wr_en = cmd_i.mem_wr_char | cmd_i.col_dec_erase | cmd_i.clr_step | cmd_i.wipe_step;
    if (cmd_i.col_dec_erase) begin
      wr_col = col_q - 1'b1;
    end else if (cmd_i.clr_step) begin
      wr_col = clr_q;
    end else begin
      wr_col = col_q;
    end
    wr_addr = cmd_i.wipe_step ? wipe_q : {row_q[RowAw-1:0], wr_col};
    wr_data = cmd_i.mem_wr_char ? ch_q : '0;
    rd_en   = cmd_i.scan_start | cmd_i.scan_step;
    rd_col  = cmd_i.scan_start ? ColLast : scan_q - 1'b1;
    rd_addr = {row_q[RowAw-1:0], rd_col};
  end

  // Character buffer with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Input word and output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ch_load) begin
      ch_q <= char_code_i;
    end
    if (cmd_i.out_load) begin
      out_row_q <= row_q;
      out_col_q <= col_q;
      out_fv_q  <= fv_q;
    end
  end

  // Cursor, top line and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      fv_q   <= '0;
      clr_q  <= '0;
      scan_q <= '0;
      wipe_q <= '0;
    end else begin
      if (cmd_i.wipe_step) begin
        wipe_q <= wipe_q + 1'b1;
      end
      if (cmd_i.nl_start) begin
        row_q <= row_next;
        col_q <= '0;
        clr_q <= '0;
        if (scroll) begin
          fv_q <= fv_next;
        end
      end else if (cmd_i.col_inc) begin
        col_q <= col_q + 1'b1;
      end else if (cmd_i.col_dec_erase) begin
        col_q <= col_q - 1'b1;
      end else if (cmd_i.row_back) begin
        row_q <= row_prev;
      end else if (cmd_i.scan_hit) begin
        col_q <= scan_q + 1'b1;
      end else if (cmd_i.scan_empty) begin
        col_q <= '0;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.scan_start) begin
        scan_q <= ColLast;
      end else if (cmd_i.scan_step) begin
        scan_q <= scan_q - 1'b1;
      end
    end
  end

  // Status to the controller.
  always_comb begin
    st_o.is_bs     = ch_q == tcw_pkg::CharBackspace;
    st_o.is_nl     = ch_q == tcw_pkg::CharNewline;
    st_o.col_zero  = col_q == '0;
    st_o.on_top    = row_q == fv_q;
    st_o.wrap      = col_q >= ColLast;
    st_o.clr_last  = clr_q == ColLast;
    st_o.scan_nz   = rdata_q != '0;
    st_o.scan_zero = scan_q == '0;
    st_o.wipe_last = wipe_q == AddrW'(Depth - 1);
  end

  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign top_line_o   = out_fv_q;

endmodule

>>> hw/rtl/text_console_char_writer.sv
// Each accepted word is decoded, then its result is loaded into the output
// register; a newline or a wrap first clears the COLS cells of the new row,
// and a backspace at column zero off the top line first scans the previous
// row backward for its last text cell. The controller takes the next word only
// after the last result is loaded. Reset: cursor and top line clear at once,
// then a sweep zeroes all RING_ROWS * 128 buffer cells, one cell a cycle.
// ----------------------------------------------------------------------------
// Text console character writer
// Keeps a ring character buffer, a cursor and a top visible line, and reports
// the cursor and top line after each character word.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
  parameter int COLS      = tcw_pkg::ColsDefault,
  parameter int VISIBLE   = tcw_pkg::VisibleDefault,
  parameter int RING_ROWS = tcw_pkg::RingRowsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [tcw_pkg::CharW-1:0] char_code_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [tcw_pkg::RowW-1:0]  cursor_row_o,
  output logic [tcw_pkg::ColW-1:0]  cursor_col_o,
  output logic [tcw_pkg::RowW-1:0]  top_line_o
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t st;

  // Controller.
  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // Datapath.
  tcw_datapath #(
    .COLS      (COLS),
    .VISIBLE   (VISIBLE),
    .RING_ROWS (RING_ROWS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_code_i  (char_code_i),
    .cmd_i        (cmd),
    .st_o         (st),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .top_line_o   (top_line_o)
  );

endmodule
